@@ rtl/core/clt_pkg.sv @@
// ----------------------------------------------------------------------------
// clt_pkg
// Shared types and constants for the command line tokenizer.
// ----------------------------------------------------------------------------
package clt_pkg;

  localparam int LINE_MAX = 80;
  localparam int CC_W     = 7;
  localparam int TC_W     = 6;
  localparam int BYTE_W   = 8;

  localparam logic [TC_W-1:0] TC_MAX = {TC_W{1'b1}};

  localparam logic [BYTE_W-1:0] CH_CR = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_LF = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_SP = 8'h20;
  localparam logic [BYTE_W-1:0] CH_QT = 8'h22;

  typedef struct packed {
    logic              has_char;
    logic [BYTE_W-1:0] token_char;
    logic [TC_W-1:0]   token_index;
    logic              token_start;
    logic              line_done;
    logic [TC_W-1:0]   arg_count;
    logic              overflowed;
  } clt_result_t;

endpackage

@@ rtl/core/cli_line_tokenizer_top.sv @@
// ----------------------------------------------------------------------------
// cli_line_tokenizer_top
// Streaming command line tokenizer with quoted parameters.
// ----------------------------------------------------------------------------
// One received byte per input beat, one byte accepted every cycle while the
// output side keeps up. A byte passes an input register, is classified
// against the scan state, and its result (if any) lands in the output
// register. Bytes that produce no result (separators, quotes, discarded
// bytes) emit no beat. tlast marks the beat that ends a line and carries the
// parameter count and overflow flag. Throughput is one byte per cycle as long
// as the output side keeps up.
module cli_line_tokenizer_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [7:0] token_char, [13:8] token_index,
                                      // [14] token_start, [20:15] arg_count,
                                      // [21] overflowed, [23:22] zero
  output logic        m_axis_tuser,   // [0] has_char
  output logic        m_axis_tlast    // line_done
);

  logic                        in_valid;
  logic [clt_pkg::BYTE_W-1:0]  in_byte;
  logic                        advance;
  clt_pkg::clt_result_t        result;
  clt_pkg::clt_result_t        out_res;
  logic                        out_valid;

  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  clt_scanner u_scanner (
    .clk     (clk),
    .rst     (rst),
    .step    (advance),
    .rx_byte (in_byte),
    .result  (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte <= s_axis_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= result.has_char || result.line_done;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= result;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_res.has_char;
  assign m_axis_tlast  = out_res.line_done;
  assign m_axis_tdata  = {2'b00, out_res.overflowed, out_res.arg_count,
                          out_res.token_start, out_res.token_index,
                          out_res.token_char};

  a_no_empty_beat: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tuser || m_axis_tlast))
    else $error("output beat carries neither a token byte nor line end");

  a_start_has_char: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tdata[14]) |-> m_axis_tuser)
    else $error("token start without token byte");

  a_ovf_ends_line: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tdata[21]) |-> m_axis_tlast)
    else $error("overflow flag without line end");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !in_valid |-> s_axis_tready)
    else $error("input stalled with empty input register");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tready && !in_valid) |=> !m_axis_tvalid)
    else $error("output beat repeated after being taken");

endmodule

@@ rtl/core/clt_scanner.sv @@
// ----------------------------------------------------------------------------
// clt_scanner
// Scan state and per-byte classification; result is combinational from the
// current state and byte, state advances when step is high.
// ----------------------------------------------------------------------------
module clt_scanner (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         step,
  input  logic [clt_pkg::BYTE_W-1:0]   rx_byte,
  output clt_pkg::clt_result_t         result
);

  typedef enum logic [2:0] {
    EXP_CMD   = 3'd0,
    WORD      = 3'd1,
    EXP_PARAM = 3'd2,
    QLEAD     = 3'd3,
    QUOTED    = 3'd4,
    DISCARD   = 3'd5
  } mode_t;

  mode_t                     mode, mode_next;
  logic [clt_pkg::CC_W-1:0]  char_count, char_count_next, cc_inc;
  logic [clt_pkg::TC_W-1:0]  token_count, token_count_next, tc_new;
  logic                      emit, first, done, ovf, start;
  logic                      is_cr, is_lf, is_sp, is_qt;

  assign is_cr = (rx_byte == clt_pkg::CH_CR);
  assign is_lf = (rx_byte == clt_pkg::CH_LF);
  assign is_sp = (rx_byte == clt_pkg::CH_SP);
  assign is_qt = (rx_byte == clt_pkg::CH_QT);
  assign cc_inc = char_count + clt_pkg::CC_W'(1);
  assign tc_new = (start && token_count != clt_pkg::TC_MAX) ?
                  token_count + clt_pkg::TC_W'(1) : token_count;

  always_comb begin
    mode_next        = mode;
    char_count_next  = char_count;
    token_count_next = token_count;
    emit  = 1'b0;
    first = 1'b0;
    done  = 1'b0;
    ovf   = 1'b0;
    start = 1'b0;
    if (mode == DISCARD) begin
      if (is_cr || is_lf) begin
        mode_next        = EXP_CMD;
        char_count_next  = '0;
        token_count_next = '0;
      end
    end else begin
      if (is_cr) begin
        done = 1'b1;
      end else begin
        unique case (mode)
          WORD: begin
            if (is_sp || is_lf) mode_next = EXP_PARAM;
            else emit = 1'b1;
          end
          EXP_PARAM: begin
            if (is_qt) begin
              mode_next = QLEAD;
            end else if (!is_sp && !is_lf) begin
              start = 1'b1; emit = 1'b1; first = 1'b1; mode_next = WORD;
            end
          end
          QLEAD: begin
            if (!is_qt && !is_lf) begin
              start = 1'b1; emit = 1'b1; first = 1'b1; mode_next = QUOTED;
            end
          end
          QUOTED: begin
            if (is_qt || is_lf) mode_next = EXP_PARAM;
            else emit = 1'b1;
          end
          default: begin
            if (!is_sp && !is_lf) begin
              start = 1'b1; emit = 1'b1; first = 1'b1; mode_next = WORD;
            end else begin
              mode_next = EXP_CMD;
            end
          end
        endcase
        char_count_next = cc_inc;
        if (cc_inc >= clt_pkg::CC_W'(clt_pkg::LINE_MAX)) begin
          done = 1'b1;
          ovf  = 1'b1;
        end
      end
      token_count_next = tc_new;
      if (done) begin
        char_count_next  = '0;
        token_count_next = '0;
        mode_next        = ovf ? DISCARD : EXP_CMD;
      end
    end
  end

  always_comb begin
    result.has_char    = emit;
    result.token_char  = emit ? rx_byte : '0;
    result.token_index = (emit && tc_new != '0) ? tc_new - clt_pkg::TC_W'(1) : '0;
    result.token_start = first;
    result.line_done   = done;
    result.arg_count   = (done && tc_new != '0) ? tc_new - clt_pkg::TC_W'(1) : '0;
    result.overflowed  = done && ovf;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= EXP_CMD;
      char_count  <= '0;
      token_count <= '0;
    end else if (step) begin
      mode        <= mode_next;
      char_count  <= char_count_next;
      token_count <= token_count_next;
    end
  end

endmodule
